/* design/vna_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vna_pkg
// Shared types and constants of the vertex normal accumulator: beat
// structs of both channels, the command passed from front to back and the
// fixed-point widths.
// ----------------------------------------------------------------------------
package vna_pkg;

    // field widths
    localparam int IDX_W = 12;
    localparam int POS_W = 16;
    localparam int NRM_W = 16;
    localparam int SUM_W = 24;
    // width of a vector handed to the normalizer (cross product or sum)
    localparam int VEC_W = 36;

    // default mesh size
    localparam int DEF_VERTICES = 4096;

    // opcodes of an input beat
    localparam logic [1:0] OP_LOAD = 2'd0;
    localparam logic [1:0] OP_TRI  = 2'd1;
    localparam logic [1:0] OP_READ = 2'd2;
    localparam logic [1:0] OP_NOP  = 2'd3;

    // saturation bounds of a sum component
    localparam logic [SUM_W-1:0] SUM_MAX = 24'h7FFFFF;
    localparam logic [SUM_W-1:0] SUM_MIN = 24'h800000;

    // one in Q1.14
    localparam logic [16:0] ONE_Q14 = 17'd16384;

    typedef struct packed {
        logic [1:0]              opcode;
        logic [IDX_W-1:0]        vertex_index;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
        logic [IDX_W-1:0]        corner_a;
        logic [IDX_W-1:0]        corner_b;
        logic [IDX_W-1:0]        corner_c;
    } t_in_item;

    typedef struct packed {
        logic [IDX_W-1:0]        out_vertex;
        logic signed [NRM_W-1:0] normal_x;
        logic signed [NRM_W-1:0] normal_y;
        logic signed [NRM_W-1:0] normal_z;
    } t_out_item;

    // work kinds after classification
    typedef enum logic [1:0] {
        CMD_LOAD,
        CMD_TRI,
        CMD_READ,
        CMD_READ_ZERO
    } t_cmd_kind;

    // one queued command; idx_a is the vertex of a load or read
    typedef struct packed {
        t_cmd_kind               kind;
        logic [IDX_W-1:0]        idx_a;
        logic [IDX_W-1:0]        idx_b;
        logic [IDX_W-1:0]        idx_c;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_cmd;

    // normalizer result, valid for one cycle
    typedef struct packed {
        logic                    valid;
        logic signed [NRM_W-1:0] x;
        logic signed [NRM_W-1:0] y;
        logic signed [NRM_W-1:0] z;
    } t_unit_res;

endpackage

/* design/vna_ram.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vna_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data.
// ----------------------------------------------------------------------------
module vna_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

/* design/vna_front.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vna_front
// Input side: takes beats, drops no-ops and out-of-range loads and
// triangles, and queues the rest as commands for the back end.
// ----------------------------------------------------------------------------
module vna_front import vna_pkg::*; #(
    parameter int VERTICES = DEF_VERTICES
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_hold,
    input  wire logic     i_valid,
    output logic          o_ready,
    input  wire t_in_item i_data,
    output logic          o_cmd_valid,
    input  wire logic     i_cmd_ready,
    output t_cmd          o_cmd
);

    localparam int QD = 2;

    t_cmd       r_q [QD];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    logic accept;
    logic drop;
    logic push;
    logic pop;
    logic ra;
    logic rb;
    logic rc;
    t_cmd cmd;

    function automatic logic in_range(input logic [IDX_W-1:0] idx);
        return 32'(idx) < 32'(VERTICES);
    endfunction

    // classify the incoming beat
    always_comb begin
        ra = in_range((i_data.opcode == OP_TRI) ? i_data.corner_a : i_data.vertex_index);
        rb = in_range(i_data.corner_b);
        rc = in_range(i_data.corner_c);
        cmd.idx_a = (i_data.opcode == OP_TRI) ? i_data.corner_a : i_data.vertex_index;
        cmd.idx_b = i_data.corner_b;
        cmd.idx_c = i_data.corner_c;
        cmd.pos_x = i_data.pos_x;
        cmd.pos_y = i_data.pos_y;
        cmd.pos_z = i_data.pos_z;
        case (i_data.opcode)
            OP_LOAD: begin
                cmd.kind = CMD_LOAD;
                drop     = !ra;
            end
            OP_TRI: begin
                cmd.kind = CMD_TRI;
                drop     = !(ra && rb && rc);
            end
            OP_READ: begin
                cmd.kind = ra ? CMD_READ : CMD_READ_ZERO;
                drop     = 1'b0;
            end
            default: begin
                cmd.kind = CMD_LOAD;
                drop     = 1'b1;
            end
        endcase
    end

    // queue handshakes
    assign o_ready     = (r_cnt != 2'(QD)) && !i_hold;
    assign accept      = i_valid && o_ready;
    assign push        = accept && !drop;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign pop         = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    // command queue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) begin
                r_q[r_wp] <= cmd;
                r_wp      <= ~r_wp;
            end
            if (pop) begin
                r_rp <= ~r_rp;
            end
            case ({push, pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    // queue never overfills
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 2'(QD))
        else $error("command queue overfilled");

    // nothing accepted during the clearing pass
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_hold |-> !o_ready)
        else $error("beat accepted during clearing pass");

    // a dropped beat leaves no entry behind
    a_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && drop && !pop) |=> (r_cnt == $past(r_cnt)))
        else $error("dropped beat changed queue fill");

endmodule
`default_nettype wire

/* design/vna_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vna_unit
// Normalizer: scales a signed 3-vector to unit length in Q1.14. Iterative:
// magnitude alignment, serial sum of squares, bit-serial square root and a
// shared restoring divider for the three components.
// ----------------------------------------------------------------------------
module vna_unit import vna_pkg::*; (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic signed [VEC_W-1:0] i_vec_x,
    input  wire logic signed [VEC_W-1:0] i_vec_y,
    input  wire logic signed [VEC_W-1:0] i_vec_z,
    output t_unit_res                    o_res
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_SQ,
        S_ROOT,
        S_DIVINIT,
        S_DIV
    } t_state;

    localparam int MAG_W = VEC_W;
    localparam int RT_W  = 62;
    localparam int DV_W  = 48;

    localparam logic [MAG_W-1:0] LIM_R4 = MAG_W'(64'd1 << 33);
    localparam logic [MAG_W-1:0] LIM_R1 = MAG_W'(64'd1 << 30);
    localparam logic [MAG_W-1:0] LIM_L4 = MAG_W'(64'd1 << 25);
    localparam logic [MAG_W-1:0] LIM_L1 = MAG_W'(64'd1 << 29);
    localparam logic [RT_W-1:0]  BIT_TOP = RT_W'(64'd1 << 60);

    t_state                  r_state;
    logic [MAG_W-1:0]        r_mag [3];
    logic [2:0]              r_neg;
    logic [RT_W-1:0]         r_acc;
    logic [RT_W-1:0]         r_n;
    logic [RT_W-1:0]         r_res;
    logic [RT_W-1:0]         r_bit;
    logic [DV_W-1:0]         r_rem;
    logic [DV_W-1:0]         r_dsh;
    logic [16:0]             r_q;
    logic [4:0]              r_i;
    logic [1:0]              r_k;
    logic signed [NRM_W-1:0] r_nrm [3];
    logic                    r_done;

    logic [MAG_W-1:0]        in_mag [3];
    logic [MAG_W-1:0]        m_max;
    logic [MAG_W-1:0]        mag_k;
    logic [29:0]             sq_op;
    logic [59:0]             sq;
    logic [RT_W-1:0]         trial;
    logic                    root_ge;
    logic                    div_ge;
    logic [16:0]             q_next;
    logic [16:0]             q_clamp;
    logic signed [NRM_W-1:0] q_pos;
    logic signed [NRM_W-1:0] q_signed;

    function automatic logic [MAG_W-1:0] abs_v(input logic signed [VEC_W-1:0] v);
        return v[VEC_W-1] ? MAG_W'(-v) : MAG_W'(v);
    endfunction

    // datapath helpers
    always_comb begin
        in_mag[0] = abs_v(i_vec_x);
        in_mag[1] = abs_v(i_vec_y);
        in_mag[2] = abs_v(i_vec_z);
        m_max = (r_mag[0] > r_mag[1]) ? r_mag[0] : r_mag[1];
        if (r_mag[2] > m_max) begin
            m_max = r_mag[2];
        end
        case (r_k)
            2'd0:    mag_k = r_mag[0];
            2'd1:    mag_k = r_mag[1];
            default: mag_k = r_mag[2];
        endcase
        sq_op    = mag_k[29:0];
        sq       = sq_op * sq_op;
        trial    = r_res + r_bit;
        root_ge  = (r_n >= trial);
        div_ge   = (r_rem >= r_dsh);
        q_next   = {r_q[15:0], div_ge};
        q_clamp  = (q_next > ONE_Q14) ? ONE_Q14 : q_next;
        q_pos    = $signed({1'b0, q_clamp[14:0]});
        q_signed = r_neg[r_k] ? -q_pos : q_pos;
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            // done after a zero vector or after the last quotient bit
            r_done <= ((r_state == S_IDLE) && i_start
                       && ((in_mag[0] | in_mag[1] | in_mag[2]) == '0))
                   || ((r_state == S_DIV) && (r_i == 5'd0) && (r_k == 2'd2));
            case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_mag[0] <= in_mag[0];
                        r_mag[1] <= in_mag[1];
                        r_mag[2] <= in_mag[2];
                        r_neg    <= {i_vec_z[VEC_W-1], i_vec_y[VEC_W-1], i_vec_x[VEC_W-1]};
                        if ((in_mag[0] | in_mag[1] | in_mag[2]) == '0) begin
                            // zero vector gives zero
                            r_nrm[0] <= '0;
                            r_nrm[1] <= '0;
                            r_nrm[2] <= '0;
                        end else begin
                            r_state <= S_SHIFT;
                        end
                    end
                end
                S_SHIFT: begin
                    // bring the largest magnitude into [2^29, 2^30)
                    if (m_max >= LIM_R4) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 4;
                    end else if (m_max >= LIM_R1) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
                    end else if (m_max < LIM_L4) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 4;
                    end else if (m_max < LIM_L1) begin
                        for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
                    end else begin
                        r_acc   <= '0;
                        r_k     <= 2'd0;
                        r_state <= S_SQ;
                    end
                end
                S_SQ: begin
                    // one square per cycle
                    if (r_k == 2'd2) begin
                        r_n     <= r_acc + RT_W'(sq);
                        r_res   <= '0;
                        r_bit   <= BIT_TOP;
                        r_state <= S_ROOT;
                    end else begin
                        r_acc <= r_acc + RT_W'(sq);
                        r_k   <= r_k + 2'd1;
                    end
                end
                S_ROOT: begin
                    // one result bit per cycle
                    if (root_ge) begin
                        r_n   <= r_n - trial;
                        r_res <= (r_res >> 1) + r_bit;
                    end else begin
                        r_res <= r_res >> 1;
                    end
                    r_bit <= r_bit >> 2;
                    if (r_bit[0]) begin
                        r_k     <= 2'd0;
                        r_state <= S_DIVINIT;
                    end
                end
                S_DIVINIT: begin
                    // numerator mag*2^15 + len, divisor 2*len aligned to quotient msb
                    r_rem   <= DV_W'({mag_k[29:0], 15'd0}) + DV_W'(r_res[30:0]);
                    r_dsh   <= {r_res[30:0], 17'd0};
                    r_q     <= '0;
                    r_i     <= 5'd16;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // restoring division, one quotient bit per cycle
                    if (div_ge) begin
                        r_rem <= r_rem - r_dsh;
                    end
                    r_dsh <= r_dsh >> 1;
                    r_q   <= q_next;
                    if (r_i == 5'd0) begin
                        r_nrm[r_k] <= q_signed;
                        if (r_k == 2'd2) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 2'd1;
                            r_state <= S_DIVINIT;
                        end
                    end else begin
                        r_i <= r_i - 5'd1;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_res = '{valid: r_done, x: r_nrm[0], y: r_nrm[1], z: r_nrm[2]};

    // start only lands on an idle unit
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("normalizer started while busy");

    // square root walks one bit pair at a time
    a_root_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_ROOT) |-> $onehot(r_bit))
        else $error("square root trial bit lost");

    // results stay within one in Q1.14
    a_unit_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |-> (r_nrm[0] <= 16'sd16384 && r_nrm[0] >= -16'sd16384
                 && r_nrm[1] <= 16'sd16384 && r_nrm[1] >= -16'sd16384
                 && r_nrm[2] <= 16'sd16384 && r_nrm[2] >= -16'sd16384))
        else $error("normal component beyond unit range");

endmodule
`default_nettype wire

/* design/vna_back.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vna_back
// Execution side: owns the position and normal-sum memories, runs the
// clearing pass, the face normal and the per-corner saturating updates, and
// holds the output register.
// ----------------------------------------------------------------------------
module vna_back import vna_pkg::*; #(
    parameter int VERTICES = DEF_VERTICES
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    output logic      o_clearing,
    input  wire logic i_cmd_valid,
    output logic      o_cmd_ready,
    input  wire t_cmd i_cmd,
    output logic      o_valid,
    input  wire logic i_ready,
    output t_out_item o_data
);

    localparam int AW        = $clog2(VERTICES);
    localparam int IW        = (AW > IDX_W) ? AW : IDX_W;
    localparam int POS_MEM_W = 3 * POS_W;
    localparam int SUM_MEM_W = 3 * SUM_W;
    localparam logic [AW-1:0] LAST_ADDR = AW'(VERTICES - 1);

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_PRD,
        S_EDGE,
        S_MUL,
        S_SUB,
        S_TNORM,
        S_URD,
        S_UWR,
        S_RRD,
        S_RWAIT,
        S_RNORM,
        S_OUT
    } t_state;

    t_state                  r_state;
    logic [AW-1:0]           r_clr_addr;
    logic [1:0]              r_step;
    logic [1:0]              r_k;
    logic [POS_MEM_W-1:0]    r_pa;
    logic [POS_MEM_W-1:0]    r_pb;
    logic [POS_MEM_W-1:0]    r_pc;
    logic signed [16:0]      r_e1x, r_e1y, r_e1z, r_e2x, r_e2y, r_e2z;
    logic signed [33:0]      r_pr0, r_pr1, r_pr2, r_pr3, r_pr4, r_pr5;
    logic signed [VEC_W-1:0] r_vx, r_vy, r_vz;
    logic                    r_ustart;
    logic signed [NRM_W-1:0] r_nx, r_ny, r_nz;
    logic                    r_out_valid;
    t_out_item               r_out;

    logic [AW-1:0]        addr_a, addr_b, addr_c, addr_k;
    logic                 pos_we;
    logic [AW-1:0]        pos_raddr;
    logic [POS_MEM_W-1:0] pos_rdata;
    logic                 sum_we;
    logic [AW-1:0]        sum_waddr;
    logic [SUM_MEM_W-1:0] sum_wdata;
    logic [AW-1:0]        sum_raddr;
    logic [SUM_MEM_W-1:0] sum_rdata;
    logic                 do_load;
    logic                 out_free;
    t_unit_res            u_res;

    function automatic logic [AW-1:0] to_addr(input logic [IDX_W-1:0] idx);
        logic [IW-1:0] wide;
        wide = IW'(idx);
        return wide[AW-1:0];
    endfunction

    function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] s,
                                                 input logic signed [NRM_W-1:0] d);
        logic signed [SUM_W:0] r;
        r = $signed({s[SUM_W-1], s}) + (SUM_W+1)'(d);
        if (r[SUM_W] != r[SUM_W-1]) begin
            return r[SUM_W] ? SUM_MIN : SUM_MAX;
        end
        return r[SUM_W-1:0];
    endfunction

    // addresses
    always_comb begin
        addr_a = to_addr(i_cmd.idx_a);
        addr_b = to_addr(i_cmd.idx_b);
        addr_c = to_addr(i_cmd.idx_c);
        case (r_k)
            2'd0:    addr_k = addr_a;
            2'd1:    addr_k = addr_b;
            default: addr_k = addr_c;
        endcase
        case (r_step)
            2'd0:    pos_raddr = addr_a;
            2'd1:    pos_raddr = addr_b;
            default: pos_raddr = addr_c;
        endcase
        sum_raddr = (r_state == S_URD) ? addr_k : addr_a;
    end

    // memory writes and command release
    always_comb begin
        do_load  = (r_state == S_IDLE) && i_cmd_valid && (i_cmd.kind == CMD_LOAD);
        out_free = !r_out_valid || i_ready;
        pos_we   = do_load;
        sum_we    = 1'b0;
        sum_waddr = addr_a;
        sum_wdata = '0;
        case (r_state)
            S_CLEAR: begin
                sum_we    = 1'b1;
                sum_waddr = r_clr_addr;
            end
            S_IDLE: begin
                sum_we = do_load;
            end
            S_UWR: begin
                sum_we    = 1'b1;
                sum_waddr = addr_k;
                sum_wdata = {sat_add(sum_rdata[3*SUM_W-1:2*SUM_W], r_nx),
                             sat_add(sum_rdata[2*SUM_W-1:SUM_W], r_ny),
                             sat_add(sum_rdata[SUM_W-1:0], r_nz)};
            end
            default: sum_we = 1'b0;
        endcase
        o_cmd_ready = do_load
                   || ((r_state == S_UWR) && (r_k == 2'd2))
                   || ((r_state == S_OUT) && out_free);
    end

    vna_ram #(
        .WIDTH (POS_MEM_W),
        .DEPTH (VERTICES)
    ) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (pos_we),
        .i_waddr (addr_a),
        .i_wdata ({i_cmd.pos_x, i_cmd.pos_y, i_cmd.pos_z}),
        .i_raddr (pos_raddr),
        .o_rdata (pos_rdata)
    );

    vna_ram #(
        .WIDTH (SUM_MEM_W),
        .DEPTH (VERTICES)
    ) u_sum_ram (
        .i_clk   (i_clk),
        .i_we    (sum_we),
        .i_waddr (sum_waddr),
        .i_wdata (sum_wdata),
        .i_raddr (sum_raddr),
        .o_rdata (sum_rdata)
    );

    vna_unit u_unit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_ustart),
        .i_vec_x (r_vx),
        .i_vec_y (r_vy),
        .i_vec_z (r_vz),
        .o_res   (u_res)
    );

    // sequencer and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_ustart    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            // normalizer starts after the cross product or the sum read
            r_ustart    <= (r_state == S_SUB) || (r_state == S_RWAIT);
            // output beat loads in S_OUT and holds until taken
            r_out_valid <= ((r_state == S_OUT) && out_free) || (r_out_valid && !i_ready);
            case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + AW'(1);
                    if (r_clr_addr == LAST_ADDR) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_cmd_valid) begin
                        case (i_cmd.kind)
                            CMD_TRI: begin
                                r_step  <= 2'd0;
                                r_state <= S_PRD;
                            end
                            CMD_READ: r_state <= S_RRD;
                            CMD_READ_ZERO: begin
                                r_nx    <= '0;
                                r_ny    <= '0;
                                r_nz    <= '0;
                                r_state <= S_OUT;
                            end
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_PRD: begin
                    // corner positions arrive one per cycle
                    r_step <= r_step + 2'd1;
                    case (r_step)
                        2'd1: r_pa <= pos_rdata;
                        2'd2: r_pb <= pos_rdata;
                        2'd3: begin
                            r_pc    <= pos_rdata;
                            r_state <= S_EDGE;
                        end
                        default: r_pa <= r_pa;
                    endcase
                end
                S_EDGE: begin
                    r_e1x   <= 17'($signed(r_pb[47:32])) - 17'($signed(r_pa[47:32]));
                    r_e1y   <= 17'($signed(r_pb[31:16])) - 17'($signed(r_pa[31:16]));
                    r_e1z   <= 17'($signed(r_pb[15:0]))  - 17'($signed(r_pa[15:0]));
                    r_e2x   <= 17'($signed(r_pc[47:32])) - 17'($signed(r_pa[47:32]));
                    r_e2y   <= 17'($signed(r_pc[31:16])) - 17'($signed(r_pa[31:16]));
                    r_e2z   <= 17'($signed(r_pc[15:0]))  - 17'($signed(r_pa[15:0]));
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_pr0   <= r_e1y * r_e2z;
                    r_pr1   <= r_e1z * r_e2y;
                    r_pr2   <= r_e1z * r_e2x;
                    r_pr3   <= r_e1x * r_e2z;
                    r_pr4   <= r_e1x * r_e2y;
                    r_pr5   <= r_e1y * r_e2x;
                    r_state <= S_SUB;
                end
                S_SUB: begin
                    r_vx     <= VEC_W'(r_pr0) - VEC_W'(r_pr1);
                    r_vy     <= VEC_W'(r_pr2) - VEC_W'(r_pr3);
                    r_vz     <= VEC_W'(r_pr4) - VEC_W'(r_pr5);
                    r_state  <= S_TNORM;
                end
                S_TNORM: begin
                    if (u_res.valid) begin
                        r_nx    <= u_res.x;
                        r_ny    <= u_res.y;
                        r_nz    <= u_res.z;
                        r_k     <= 2'd0;
                        r_state <= S_URD;
                    end
                end
                S_URD: r_state <= S_UWR;
                S_UWR: begin
                    if (r_k == 2'd2) begin
                        r_state <= S_IDLE;
                    end else begin
                        r_k     <= r_k + 2'd1;
                        r_state <= S_URD;
                    end
                end
                S_RRD: r_state <= S_RWAIT;
                S_RWAIT: begin
                    r_vx     <= VEC_W'($signed(sum_rdata[3*SUM_W-1:2*SUM_W]));
                    r_vy     <= VEC_W'($signed(sum_rdata[2*SUM_W-1:SUM_W]));
                    r_vz     <= VEC_W'($signed(sum_rdata[SUM_W-1:0]));
                    r_state  <= S_RNORM;
                end
                S_RNORM: begin
                    if (u_res.valid) begin
                        r_nx    <= u_res.x;
                        r_ny    <= u_res.y;
                        r_nz    <= u_res.z;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out       <= '{out_vertex: i_cmd.idx_a, normal_x: r_nx,
                                         normal_y: r_ny, normal_z: r_nz};
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_clearing = (r_state == S_CLEAR);
    assign o_valid    = r_out_valid;
    assign o_data     = r_out;

    // a command is released only while one is presented
    a_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd_ready |-> i_cmd_valid)
        else $error("command released with none queued");

    // normalizer results only come back while waited for
    a_unit_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        u_res.valid |-> (r_state == S_TNORM || r_state == S_RNORM))
        else $error("unexpected normalizer result");

    // clearing pass takes no work
    a_clear_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!o_cmd_ready && !pos_we))
        else $error("command executed during clearing pass");

    // the third corner update ends the triangle
    a_tri_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UWR && r_k == 2'd2) |=> (r_state == S_IDLE))
        else $error("triangle update did not finish");

endmodule
`default_nettype wire

/* design/vertex_normal_accumulator_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// vertex_normal_accumulator_top
// Smooth vertex normals from triangle face normals. After reset the block
// sweeps the normal-sum memory to zero, one vertex per cycle, and takes no
// beat until the sweep is done. Beats then enter a two-deep command queue;
// no-ops and out-of-range loads and triangles are dropped at the door.
// A load writes the position and clears the sum from the idle state. A
// triangle runs the position reads, the edge and cross-product math and
// the normalizer, then a read-modify-write on the sum memory for each
// corner. A read runs a sum read plus the normalizer. The normalizer
// runs magnitude alignment, the sum of squares, the bit-serial square
// root and the restoring divider for each component. Items are executed
// one at a time.
// ----------------------------------------------------------------------------
module vertex_normal_accumulator_top import vna_pkg::*; #(
    parameter int VERTICES = DEF_VERTICES
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    output logic           o_ready,
    input  wire t_in_item  i_data,
    output logic           o_valid,
    input  wire logic      i_ready,
    output t_out_item      o_data
);

    logic cmd_valid;
    logic cmd_ready;
    t_cmd cmd;
    logic clearing;

    // intake and classification
    vna_front #(
        .VERTICES (VERTICES)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_hold      (clearing),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_cmd_valid (cmd_valid),
        .i_cmd_ready (cmd_ready),
        .o_cmd       (cmd)
    );

    // execution
    vna_back #(
        .VERTICES (VERTICES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .o_clearing  (clearing),
        .i_cmd_valid (cmd_valid),
        .o_cmd_ready (cmd_ready),
        .i_cmd       (cmd),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data)
    );

endmodule
`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for vertex_normal_accumulator_top. A directed list of
// loads, triangles and reads covers extreme positions, degenerate faces, a
// zero sum on read, the unused opcode and sum saturation. A random list of
// mesh builds with noise follows. Expected normals come from a bit-exact
// fixed-point model kept in the bench and are checked beat by beat.
// ----------------------------------------------------------------------------
module tb;
    import vna_pkg::*;

    localparam int NV         = DEF_VERTICES;
    localparam int SAT_TRIS   = 515;
    localparam int RAND_ITEMS = 110;

    logic      i_clk;
    logic      i_rst_n;
    logic      i_valid;
    logic      o_ready;
    t_in_item  i_data;
    logic      o_valid;
    logic      i_ready;
    t_out_item o_data;

    vertex_normal_accumulator_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_data  (i_data),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_data  (o_data)
    );

    // mesh model: positions and saturating normal sums
    logic signed [POS_W-1:0] mesh_px [NV];
    logic signed [POS_W-1:0] mesh_py [NV];
    logic signed [POS_W-1:0] mesh_pz [NV];
    int                      nsum_x  [NV];
    int                      nsum_y  [NV];
    int                      nsum_z  [NV];

    t_in_item  pending_beats [$];
    t_out_item expected_normals [$];
    int        errors;
    int        beats_in;
    int        normals_seen;
    int        tri_count;
    int        read_count;

    // ------------------------------------------------------------------------
    // fixed-point helpers
    // ------------------------------------------------------------------------
    // scale a vector to unit length in Q1.14, zero stays zero
    function automatic void unit_q14(input longint vx, input longint vy, input longint vz,
                                     output logic signed [NRM_W-1:0] ox,
                                     output logic signed [NRM_W-1:0] oy,
                                     output logic signed [NRM_W-1:0] oz);
        longint          v [3];
        longint unsigned mg [3];
        longint unsigned m, sq, len, res, bitv, q;
        logic signed [NRM_W-1:0] o [3];
        v[0] = vx; v[1] = vy; v[2] = vz;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            mg[i] = (v[i] < 0) ? longint'(-v[i]) : longint'(v[i]);
            if (mg[i] > m) m = mg[i];
        end
        if (m == 0) begin
            ox = '0; oy = '0; oz = '0;
            return;
        end
        while (m >= (64'd1 << 30)) begin
            m = m >> 1;
            for (int i = 0; i < 3; i++) mg[i] = mg[i] >> 1;
        end
        while (m < (64'd1 << 29)) begin
            m = m << 1;
            for (int i = 0; i < 3; i++) mg[i] = mg[i] << 1;
        end
        sq = 0;
        for (int i = 0; i < 3; i++) sq += mg[i] * mg[i];
        // integer square root, bit by bit
        res = 0;
        bitv = 64'd1 << 62;
        while (bitv > sq) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (sq >= res + bitv) begin
                sq = sq - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        len = res;
        for (int i = 0; i < 3; i++) begin
            q = ((mg[i] << 15) + len) / (len << 1);
            if (q > 16384) q = 16384;
            o[i] = (v[i] < 0) ? -NRM_W'(q) : NRM_W'(q);
        end
        ox = o[0]; oy = o[1]; oz = o[2];
    endfunction

    function automatic int sat_sum(input int s, input int d);
        int r;
        r = s + d;
        if (r > 8388607) r = 8388607;
        if (r < -8388608) r = -8388608;
        return r;
    endfunction

    // update the mesh model with one accepted beat
    task automatic apply_beat(input t_in_item b);
        longint e1x, e1y, e1z, e2x, e2y, e2z;
        logic signed [NRM_W-1:0] nx, ny, nz;
        int a, bb, c;
        t_out_item r;
        case (b.opcode)
            OP_LOAD: begin
                mesh_px[b.vertex_index] = b.pos_x;
                mesh_py[b.vertex_index] = b.pos_y;
                mesh_pz[b.vertex_index] = b.pos_z;
                nsum_x[b.vertex_index] = 0;
                nsum_y[b.vertex_index] = 0;
                nsum_z[b.vertex_index] = 0;
            end
            OP_TRI: begin
                a = int'(b.corner_a); bb = int'(b.corner_b); c = int'(b.corner_c);
                e1x = longint'(mesh_px[bb]) - longint'(mesh_px[a]);
                e1y = longint'(mesh_py[bb]) - longint'(mesh_py[a]);
                e1z = longint'(mesh_pz[bb]) - longint'(mesh_pz[a]);
                e2x = longint'(mesh_px[c]) - longint'(mesh_px[a]);
                e2y = longint'(mesh_py[c]) - longint'(mesh_py[a]);
                e2z = longint'(mesh_pz[c]) - longint'(mesh_pz[a]);
                unit_q14(e1y * e2z - e1z * e2y, e1z * e2x - e1x * e2z,
                         e1x * e2y - e1y * e2x, nx, ny, nz);
                nsum_x[a]  = sat_sum(nsum_x[a], int'(nx));
                nsum_y[a]  = sat_sum(nsum_y[a], int'(ny));
                nsum_z[a]  = sat_sum(nsum_z[a], int'(nz));
                nsum_x[bb] = sat_sum(nsum_x[bb], int'(nx));
                nsum_y[bb] = sat_sum(nsum_y[bb], int'(ny));
                nsum_z[bb] = sat_sum(nsum_z[bb], int'(nz));
                nsum_x[c]  = sat_sum(nsum_x[c], int'(nx));
                nsum_y[c]  = sat_sum(nsum_y[c], int'(ny));
                nsum_z[c]  = sat_sum(nsum_z[c], int'(nz));
                tri_count++;
            end
            OP_READ: begin
                r.out_vertex = b.vertex_index;
                unit_q14(longint'(nsum_x[b.vertex_index]), longint'(nsum_y[b.vertex_index]),
                         longint'(nsum_z[b.vertex_index]),
                         r.normal_x, r.normal_y, r.normal_z);
                expected_normals.push_back(r);
                read_count++;
            end
            default: ;
        endcase
    endtask

    task automatic report(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        errors++;
    endtask

    // ------------------------------------------------------------------------
    // beat builders, unused fields random
    // ------------------------------------------------------------------------
    function automatic t_in_item noise_beat();
        t_in_item   b;
        logic [127:0] raw;
        raw = {$urandom, $urandom, $urandom, $urandom};
        b = raw[$bits(t_in_item)-1:0];
        return b;
    endfunction

    function automatic t_in_item load_beat(input int idx, input int x, input int y,
                                           input int z);
        t_in_item b;
        b = noise_beat();
        b.opcode = OP_LOAD;
        b.vertex_index = IDX_W'(idx);
        b.pos_x = POS_W'(x); b.pos_y = POS_W'(y); b.pos_z = POS_W'(z);
        return b;
    endfunction

    function automatic t_in_item tri_beat(input int a, input int bb, input int c);
        t_in_item b;
        b = noise_beat();
        b.opcode = OP_TRI;
        b.corner_a = IDX_W'(a); b.corner_b = IDX_W'(bb); b.corner_c = IDX_W'(c);
        return b;
    endfunction

    function automatic t_in_item read_beat(input int idx);
        t_in_item b;
        b = noise_beat();
        b.opcode = OP_READ;
        b.vertex_index = IDX_W'(idx);
        return b;
    endfunction

    // ------------------------------------------------------------------------
    // clock and reset
    // ------------------------------------------------------------------------
    initial i_clk = 1'b0;
    always #2 i_clk = ~i_clk;

    initial begin
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    // ------------------------------------------------------------------------
    // stimulus lists
    // ------------------------------------------------------------------------
    initial begin
        int       mesh_pool [$];
        bit       loaded [NV];
        int       a, bb, c, pick;
        t_in_item nb;
        errors = 0; beats_in = 0; normals_seen = 0; tri_count = 0; read_count = 0;
        for (int i = 0; i < NV; i++) begin
            mesh_px[i] = '0; mesh_py[i] = '0; mesh_pz[i] = '0;
            nsum_x[i] = 0; nsum_y[i] = 0; nsum_z[i] = 0;
        end

        // directed: extreme positions, degenerate faces, zero sums, noop
        pending_beats.push_back(load_beat(0, 0, 0, 0));
        pending_beats.push_back(load_beat(1, 32767, 0, -32768));
        pending_beats.push_back(load_beat(2, -32768, -32768, -32768));
        pending_beats.push_back(load_beat(3, 32767, 32767, 32767));
        pending_beats.push_back(load_beat(4095, -32768, 32767, 0));
        pending_beats.push_back(tri_beat(0, 1, 4095));
        pending_beats.push_back(tri_beat(2, 3, 4095));
        pending_beats.push_back(tri_beat(0, 0, 1));
        pending_beats.push_back(tri_beat(0, 2, 3));
        nb = noise_beat(); nb.opcode = OP_NOP;
        pending_beats.push_back(nb);
        pending_beats.push_back(read_beat(0));
        pending_beats.push_back(read_beat(1));
        pending_beats.push_back(read_beat(2));
        pending_beats.push_back(read_beat(3));
        pending_beats.push_back(read_beat(4095));
        pending_beats.push_back(read_beat(100));
        pending_beats.push_back(load_beat(0, 256, 0, 0));
        pending_beats.push_back(read_beat(0));

        // saturation: one face with normal along +x hit until sums clip
        pending_beats.push_back(load_beat(20, 0, 0, 0));
        pending_beats.push_back(load_beat(21, 0, 256, 0));
        pending_beats.push_back(load_beat(22, 0, 0, 256));
        for (int i = 0; i < SAT_TRIS; i++) begin
            pending_beats.push_back(tri_beat(20, 21, 22));
            if (i % 120 == 119) pending_beats.push_back(read_beat(20 + i % 3));
        end
        pending_beats.push_back(read_beat(20));
        pending_beats.push_back(read_beat(21));
        pending_beats.push_back(read_beat(22));
        foreach (loaded[i]) loaded[i] = 1'b0;
        loaded[0] = 1; loaded[1] = 1; loaded[2] = 1; loaded[3] = 1; loaded[4095] = 1;
        loaded[20] = 1; loaded[21] = 1; loaded[22] = 1;
        mesh_pool = '{0, 1, 2, 3, 4095, 20, 21, 22};

        // random: mostly mesh building on loaded vertices, some noise
        for (int i = 0; i < RAND_ITEMS; i++) begin
            pick = $urandom_range(0, 99);
            if (pick < 25) begin
                a = (mesh_pool.size() < 48 || $urandom_range(0, 3) == 0)
                    ? $urandom_range(0, NV - 1)
                    : mesh_pool[$urandom_range(0, mesh_pool.size() - 1)];
                case ($urandom_range(0, 2))
                    0: pending_beats.push_back(load_beat(a, $urandom, $urandom, $urandom));
                    1: pending_beats.push_back(load_beat(a, $signed($urandom_range(0, 2047))
                                                    - 1024, $urandom_range(0, 2047) - 1024,
                                                    $urandom_range(0, 2047) - 1024));
                    default: pending_beats.push_back(load_beat(a, $urandom_range(0, 7) - 4,
                                                    $urandom_range(0, 7) - 4,
                                                    $urandom_range(0, 7) - 4));
                endcase
                if (!loaded[a]) begin
                    loaded[a] = 1'b1;
                    mesh_pool.push_back(a);
                end
            end else if (pick < 65) begin
                a  = mesh_pool[$urandom_range(0, mesh_pool.size() - 1)];
                bb = mesh_pool[$urandom_range(0, mesh_pool.size() - 1)];
                c  = mesh_pool[$urandom_range(0, mesh_pool.size() - 1)];
                pending_beats.push_back(tri_beat(a, bb, c));
            end else if (pick < 92) begin
                a = ($urandom_range(0, 4) == 0) ? $urandom_range(0, NV - 1)
                    : mesh_pool[$urandom_range(0, mesh_pool.size() - 1)];
                pending_beats.push_back(read_beat(a));
            end else begin
                nb = noise_beat(); nb.opcode = OP_NOP;
                pending_beats.push_back(nb);
            end
        end
    end

    // ------------------------------------------------------------------------
    // driver: bursts of beats with random gaps
    // ------------------------------------------------------------------------
    int burst_left;
    int gap_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid    <= 1'b0;
            i_data     <= '0;
            burst_left = $urandom_range(1, 12);
            gap_left   = 0;
        end else begin
            if (i_valid && o_ready) begin
                apply_beat(i_data);
                beats_in++;
            end
            if (!(i_valid && !o_ready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    i_data  <= pending_beats.pop_front();
                    i_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 12);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 150);
                    end
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // monitor: receiver stalls in modes, checks each normal beat
    // ------------------------------------------------------------------------
    int stall_mode;
    int mode_left;

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            i_ready    <= 1'b0;
            stall_mode = 0;
            mode_left  = 0;
        end else begin
            if (o_valid && i_ready) begin
                normals_seen++;
                if (expected_normals.size() == 0) begin
                    report($sformatf("unexpected normal beat for vertex %0d",
                                     o_data.out_vertex));
                end else begin
                    want = expected_normals.pop_front();
                    if (o_data.out_vertex !== want.out_vertex)
                        report($sformatf("vertex got %0d want %0d",
                                         o_data.out_vertex, want.out_vertex));
                    if (o_data.normal_x !== want.normal_x)
                        report($sformatf("v%0d normal_x got %0d want %0d", want.out_vertex,
                                         o_data.normal_x, want.normal_x));
                    if (o_data.normal_y !== want.normal_y)
                        report($sformatf("v%0d normal_y got %0d want %0d", want.out_vertex,
                                         o_data.normal_y, want.normal_y));
                    if (o_data.normal_z !== want.normal_z)
                        report($sformatf("v%0d normal_z got %0d want %0d", want.out_vertex,
                                         o_data.normal_z, want.normal_z));
                end
            end
            // stall pattern: always ready, random, or long holds
            if (mode_left <= 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(50, 600);
            end
            mode_left--;
            case (stall_mode)
                0:       i_ready <= 1'b1;
                1:       i_ready <= ($urandom_range(0, 2) != 0);
                default: i_ready <= ($urandom_range(0, 39) == 0);
            endcase
        end
    end

    // ------------------------------------------------------------------------
    // end of run
    // ------------------------------------------------------------------------
    initial begin
        @(posedge i_rst_n);
        wait (pending_beats.size() == 0 && !i_valid && expected_normals.size() == 0);
        repeat (300) @(posedge i_clk);
        $display("covered %0d beats: %0d faces, %0d normal reads checked",
                 beats_in, tri_count, normals_seen);
        $display("with saturation, degenerate faces, zero sums and idle opcodes");
        if (errors == 0 && expected_normals.size() == 0) begin
            $display("vertex_normal_accumulator_top regression: pass");
        end else begin
            $display("vertex_normal_accumulator_top regression: fail");
        end
        $finish;
    end

    initial begin
        #6000000;
        $display("timeout with %0d normals outstanding", expected_normals.size());
        $display("vertex_normal_accumulator_top regression: fail");
        $finish;
    end

endmodule

/* sim.f */
design/vna_pkg.sv
design/vna_ram.sv
design/vna_front.sv
design/vna_unit.sv
design/vna_back.sv
design/vertex_normal_accumulator_top.sv
test/tb.sv
